FILE: rtl/core/tracking_wheel_odometry_assert.svh
// Assertion macros for the odometry RTL
`ifndef TRACKING_WHEEL_ODOMETRY_ASSERT_SVH
`define TRACKING_WHEEL_ODOMETRY_ASSERT_SVH

// Clocked implication, muted while reset is held
`define TWO_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Clocked next-cycle implication
`define TWO_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/two_pkg.sv
package two_pkg;

    localparam int CordicSteps = 16;
    localparam int StepW = 5;

    localparam logic signed [15:0] HalfTurn = 16'sd11520;
    localparam logic signed [15:0] FullTurn = 16'sd23040;
    localparam logic signed [15:0] QuarterTurn = 16'sd5760;
    localparam logic signed [21:0] RadPerUnitQ32 = 22'sd1171271;
    localparam logic signed [33:0] CordicX0 = 34'sd652032875;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_TURN,
        S_ROT,
        S_MUL,
        S_ACC,
        S_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic set_pose;
        logic prep;
        logic turn;
        logic rot_step;
        logic mul;
        logic acc;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic rot_done;
    } t_status;

    function automatic logic [22:0] atan_val(input logic [StepW-1:0] i);
        logic [22:0] r;
        case (i)
            5'd0: r = 23'd737280;
            5'd1: r = 23'd435242;
            5'd2: r = 23'd229970;
            5'd3: r = 23'd116736;
            5'd4: r = 23'd58595;
            5'd5: r = 23'd29326;
            5'd6: r = 23'd14667;
            5'd7: r = 23'd7334;
            5'd8: r = 23'd3667;
            5'd9: r = 23'd1833;
            5'd10: r = 23'd917;
            5'd11: r = 23'd458;
            5'd12: r = 23'd229;
            5'd13: r = 23'd115;
            5'd14: r = 23'd57;
            5'd15: r = 23'd29;
            5'd16: r = 23'd14;
            5'd17: r = 23'd7;
            5'd18: r = 23'd4;
            5'd19: r = 23'd2;
            5'd20: r = 23'd1;
            default: r = 23'd0;
        endcase
        return r;
    endfunction

    // Wrap an 18-bit angle into +-HalfTurn; three folds cover inputs within HalfTurn plus three FullTurns
    function automatic logic signed [15:0] wrap_angle(input logic signed [17:0] a);
        logic signed [17:0] v;
        v = a;
        for (int k = 0; k < 3; k++) begin
            if (v > 18'(HalfTurn)) begin
                v = v - 18'(FullTurn);
            end else if (v < -18'(HalfTurn)) begin
                v = v + 18'(FullTurn);
            end
        end
        return v[15:0];
    endfunction

endpackage

FILE: rtl/core/tracking_wheel_odometry.sv
// Tracking-wheel dead-reckoning pose tracker.
// s_axis carries one request: tuser = mode (0 sample, 1 set pose), tdata
// packs odom_reading, heading_reading, new_x, new_y, new_heading, time_ms.
// m_axis returns one pose per request: pose_x, pose_y, pose_heading,
// pose_time. The cfg channel writes the wheel lateral offset (signed, 1/1024
// inch); the user must do so only while idle, the block does not enforce it.
// A sample request steps through load, wrap, turn correction, 16 CORDIC
// rotations on one shared shift-add unit, the multiply and the saturating
// accumulate. A set-pose request writes the pose registers on acceptance
// and then goes through S_OUT. One request is worked at a time, so a new
// one is taken once the previous pose has moved to the output register.
// Synchronous active-low reset zeroes pose, offsets and the lateral offset.
// While m_axis_tready is low the pose waits in the output register and a
// finished request waits in the controller; nothing is dropped.
module tracking_wheel_odometry
    import two_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] odom_reading, [47:32] heading_reading, [79:48] new_x,
    // [111:80] new_y, [127:112] new_heading, [159:128] time_ms
    input  logic [159:0] s_axis_tdata,
    // [0] mode
    input  logic         s_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [15:0]  i_cfg_data,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [47:0] pose_x, [95:48] pose_y, [110:96] pose_heading,
    // [142:111] pose_time, [143] zero
    output logic [143:0] m_axis_tdata
);

    `include "tracking_wheel_odometry_assert.svh"

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_busy, w_out_load, w_in_fire, w_out_free;
    logic signed [15:0] r_lat;
    logic               r_oval;
    logic [142:0]       r_odata;
    logic signed [47:0] w_x, w_y;
    logic signed [14:0] w_head;
    logic [31:0]        w_time;

    assign s_axis_tready = !w_busy;
    assign w_in_fire = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_oval || m_axis_tready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat <= '0;
            r_oval <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_lat <= i_cfg_data;
            end
            if (w_out_load) begin
                r_oval <= 1'b1;
            end else if (m_axis_tready) begin
                r_oval <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_odata <= {w_time, w_head, w_y, w_x};
        end
    end

    two_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (w_in_fire),
        .i_mode     (s_axis_tuser),
        .i_out_free (w_out_free),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy),
        .o_out_load (w_out_load)
    );

    two_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_lat      (r_lat),
        .i_odom     (s_axis_tdata[31:0]),
        .i_head     (s_axis_tdata[47:32]),
        .i_new_x    (s_axis_tdata[79:48]),
        .i_new_y    (s_axis_tdata[111:80]),
        .i_new_head (s_axis_tdata[127:112]),
        .i_time     (s_axis_tdata[159:128]),
        .o_status   (w_status),
        .o_x        (w_x),
        .o_y        (w_y),
        .o_head     (w_head),
        .o_time     (w_time)
    );

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata = {1'b0, r_odata};

    `TWO_ASSERT_IMP(a_no_accept_busy, w_busy, !w_in_fire, "request taken while busy")
    `TWO_ASSERT_IMP(a_load_free, w_out_load, w_out_free, "pose loaded over waiting result")
    `TWO_ASSERT_NXT(a_load_valid, w_out_load, m_axis_tvalid, "loaded pose not shown")
    `TWO_ASSERT_NXT(a_fire_busy, w_in_fire, w_busy, "accepted request not in work")

endmodule

FILE: rtl/core/two_ctrl.sv
module two_ctrl
    import two_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_fire,
    input  logic    i_mode,
    input  logic    i_out_free,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy,
    output logic    o_out_load
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_fire) begin
                    o_cmd.load = 1'b1;
                    n_state = i_mode ? S_OUT : S_PREP;
                    o_cmd.set_pose = i_mode;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = S_TURN;
            end
            S_TURN: begin
                o_cmd.turn = 1'b1;
                n_state = S_ROT;
            end
            S_ROT: begin
                o_cmd.rot_step = 1'b1;
                if (i_status.rot_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: rtl/core/two_dpath.sv
module two_dpath
    import two_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic signed [15:0]  i_lat,
    input  logic signed [31:0]  i_odom,
    input  logic signed [15:0]  i_head,
    input  logic signed [31:0]  i_new_x,
    input  logic signed [31:0]  i_new_y,
    input  logic signed [15:0]  i_new_head,
    input  logic [31:0]         i_time,
    output t_status             o_status,
    output logic signed [47:0]  o_x,
    output logic signed [47:0]  o_y,
    output logic signed [14:0]  o_head,
    output logic [31:0]         o_time
);

    localparam logic signed [48:0] PosMax = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [48:0] PosMin = -49'sh0_8000_0000_0000;

    logic signed [47:0] r_pos_x, r_pos_y;
    logic signed [15:0] r_fused, r_offset, r_last_head;
    logic [31:0]        r_last_odom, r_stamp;

    logic signed [15:0] r_raw, r_h, r_d;
    logic signed [31:0] r_odom_in, r_raw_delta;
    logic signed [31:0] r_ld;
    logic signed [33:0] r_delta_in;
    logic               r_neg;
    logic signed [33:0] r_cx, r_cy;
    logic signed [24:0] r_cz;
    logic [StepW-1:0]   r_step;
    logic signed [49:0] r_px, r_py;

    logic signed [15:0] w_h, w_fold;
    logic               w_neg;
    logic signed [31:0] w_ld;
    logic signed [53:0] w_turn_prod;
    logic signed [33:0] w_turn;
    logic signed [33:0] w_xs, w_ys;
    logic signed [22:0] w_at;
    logic signed [18:0] w_cq, w_sq;
    logic signed [15:0] w_cs, w_ss;
    logic signed [48:0] w_sx, w_sy;
    logic signed [34:0] w_rx, w_ry;

    function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
        logic signed [34:0] r;
        r = (35'(v) + 35'sd16384) >>> 15;
        if (r > 35'sd32767) begin
            return 16'sh7FFF;
        end else if (r < -35'sd32768) begin
            return 16'sh8000;
        end
        return r[15:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        if (v > PosMax) begin
            return PosMax[47:0];
        end else if (v < PosMin) begin
            return PosMin[47:0];
        end
        return v[47:0];
    endfunction

    assign w_h = wrap_angle(18'(r_raw) + 18'(r_offset));
    assign w_neg = (r_h > QuarterTurn) || (r_h < -QuarterTurn);
    assign w_fold = (r_h > QuarterTurn) ? r_h - HalfTurn :
                    (r_h < -QuarterTurn) ? r_h + HalfTurn : r_h;

    // turn travel: lateral offset * delta * pi/11520, Q32, round half up
    // offset * delta is registered in S_TURN, the Q32 scale runs during rotation
    assign w_ld = 32'(i_lat) * 32'(r_d);
    assign w_turn_prod = 54'(r_ld) * 54'(RadPerUnitQ32);
    assign w_turn = 34'((w_turn_prod + 54'sh0_8000_0000) >>> 32);

    assign w_xs = r_cx >>> r_step;
    assign w_ys = r_cy >>> r_step;
    assign w_at = 23'(atan_val(r_step));
    assign o_status.rot_done = (r_step == StepW'(CordicSteps - 1));

    assign w_cs = to_q15(r_cx);
    assign w_ss = to_q15(r_cy);
    assign w_cq = r_neg ? -19'(w_cs) : 19'(w_cs);
    assign w_sq = r_neg ? -19'(w_ss) : 19'(w_ss);

    assign w_rx = 35'((r_px + 50'sd16384) >>> 15);
    assign w_ry = 35'((r_py + 50'sd16384) >>> 15);
    assign w_sx = 49'(r_pos_x) + 49'(w_rx);
    assign w_sy = 49'(r_pos_y) + 49'(w_ry);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_fused <= '0;
            r_offset <= '0;
            r_last_head <= '0;
            r_last_odom <= '0;
            r_stamp <= '0;
            r_step <= '0;
        end else begin
            if (i_cmd.load) begin
                r_raw <= wrap_angle(18'(i_head));
                r_odom_in <= i_odom;
                r_stamp <= i_time;
            end
            if (i_cmd.set_pose) begin
                r_offset <= wrap_angle(18'(wrap_angle(18'(i_new_head)))
                                       - 18'(wrap_angle(18'(i_head))));
                r_last_head <= wrap_angle(18'(i_new_head));
                r_fused <= wrap_angle(18'(i_new_head));
                r_last_odom <= i_odom;
                r_pos_x <= 48'(i_new_x);
                r_pos_y <= 48'(i_new_y);
            end
            if (i_cmd.prep) begin
                r_h <= w_h;
                r_d <= wrap_angle(18'(w_h) - 18'(r_last_head));
                r_raw_delta <= r_odom_in - r_last_odom;
                r_last_odom <= r_odom_in;
                r_last_head <= w_h;
            end
            if (i_cmd.turn) begin
                r_ld <= w_ld;
                r_neg <= w_neg;
                r_cx <= CordicX0;
                r_cy <= '0;
                r_cz <= 25'(w_fold) * 25'sd256;
                r_step <= '0;
            end
            if (i_cmd.rot_step) begin
                r_delta_in <= 34'(r_raw_delta) - w_turn;
                if (!r_cz[24]) begin
                    r_cx <= r_cx - w_ys;
                    r_cy <= r_cy + w_xs;
                    r_cz <= r_cz - 25'(w_at);
                end else begin
                    r_cx <= r_cx + w_ys;
                    r_cy <= r_cy - w_xs;
                    r_cz <= r_cz + 25'(w_at);
                end
                r_step <= r_step + 1'b1;
            end
            if (i_cmd.mul) begin
                r_px <= 50'(r_delta_in) * 50'(w_cq);
                r_py <= 50'(r_delta_in) * 50'(w_sq);
            end
            if (i_cmd.acc) begin
                r_pos_x <= sat48(w_sx);
                r_pos_y <= sat48(w_sy);
                r_fused <= r_h;
            end
        end
    end

    assign o_x = r_pos_x;
    assign o_y = r_pos_y;
    assign o_head = r_fused[14:0];
    assign o_time = r_stamp;

endmodule

FILE: dv/tracking_wheel_odometry_tb.sv
module tracking_wheel_odometry_tb;
    import two_pkg::*;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [15:0]  i_cfg_data;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [143:0] m_axis_tdata;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_SET = 1'b1;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic        mode;
        logic [31:0] odom;
        logic [15:0] head;
        logic [31:0] nx;
        logic [31:0] ny;
        logic [15:0] nh;
        logic [31:0] tms;
    } t_req;

    typedef struct {
        t_req        req;
        logic        known;
        logic [47:0] px;
        logic [47:0] py;
        logic [14:0] ph;
    } t_row;

    tracking_wheel_odometry dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // tracker copy of the block state
    longint      trk_x, trk_y;
    int          trk_head, trk_ofs, trk_last_head, trk_lat;
    logic [31:0] trk_last_odom, trk_stamp;
    logic [143:0] pose_q[$];
    int          errors = 0;
    int          poses_seen = 0;
    int          sets_sent = 0;
    bit          calm = 0;

    localparam longint PosMax = 64'sh7FFF_FFFF_FFFF;
    localparam longint PosMin = -PosMax - 1;

    function automatic longint fl_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint rnd_shift(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic int fold_turn(int a);
        while (a > 11520) a -= 23040;
        while (a < -11520) a += 23040;
        return a;
    endfunction

    function automatic int sat_q15(longint v);
        longint r;
        r = rnd_shift(v, 15);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return int'(r);
    endfunction

    function automatic longint sat48(longint a, longint b);
        longint r;
        r = a + b;
        if (r > PosMax) r = PosMax;
        if (r < PosMin) r = PosMin;
        return r;
    endfunction

    function automatic longint arctan_step(int i);
        int tab[24] = '{737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
                        3667, 1833, 917, 458, 229, 115, 57, 29,
                        14, 7, 4, 2, 1, 0, 0, 0};
        return tab[i];
    endfunction

    task automatic heading_trig(input int h, output int s, output int c);
        bit     flip;
        longint x, y, z, xs, ys;
        flip = 0;
        x = 652032875;
        y = 0;
        if (h > 5760) begin h -= 11520; flip = 1; end
        else if (h < -5760) begin h += 11520; flip = 1; end
        z = longint'(h) * 256;
        for (int i = 0; i < CordicSteps && i < 24; i++) begin
            xs = fl_shift(x, i);
            ys = fl_shift(y, i);
            if (z >= 0) begin x = x - ys; y = y + xs; z -= arctan_step(i); end
            else begin x = x + ys; y = y - xs; z += arctan_step(i); end
        end
        c = sat_q15(x);
        s = sat_q15(y);
        if (flip) begin c = -c; s = -s; end
    endtask

    function automatic logic [143:0] pack_pose();
        logic [143:0] p;
        p = '0;
        p[47:0] = trk_x[47:0];
        p[95:48] = trk_y[47:0];
        p[110:96] = trk_head[14:0];
        p[142:111] = trk_stamp;
        return p;
    endfunction

    task automatic advance_pose(input t_req r);
        int     raw, nh, h, d, s, c;
        longint wheel, turn, travel;
        raw = fold_turn(int'($signed(r.head)));
        if (r.mode) begin
            nh = fold_turn(int'($signed(r.nh)));
            trk_ofs = fold_turn(nh - raw);
            trk_last_head = nh;
            trk_last_odom = r.odom;
            trk_x = longint'($signed(r.nx));
            trk_y = longint'($signed(r.ny));
            trk_head = nh;
        end else begin
            wheel = longint'($signed(r.odom - trk_last_odom));
            h = fold_turn(raw + trk_ofs);
            d = fold_turn(h - trk_last_head);
            trk_last_odom = r.odom;
            trk_last_head = h;
            turn = rnd_shift(longint'(trk_lat) * d * 1171271, 32);
            travel = wheel - turn;
            heading_trig(h, s, c);
            trk_x = sat48(trk_x, rnd_shift(travel * c, 15));
            trk_y = sat48(trk_y, rnd_shift(travel * s, 15));
            trk_head = h;
        end
        trk_stamp = r.tms;
        pose_q.push_back(pack_pose());
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("pose %0d: %s got %h want %h", poses_seen, what, got, want);
    endtask

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #6000000;
        $display("Mismatches found");
        $finish;
    end

    // sink side: random stalls, checks every pose
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= 18);
            if (m_axis_tvalid && m_axis_tready) begin
                if (pose_q.size() == 0) begin
                    report_mismatch("unexpected pose", m_axis_tdata[63:0], 0);
                end else begin
                    logic [143:0] w;
                    w = pose_q.pop_front();
                    if (m_axis_tdata[47:0] !== w[47:0])
                        report_mismatch("pose_x", m_axis_tdata[47:0], w[47:0]);
                    if (m_axis_tdata[95:48] !== w[95:48])
                        report_mismatch("pose_y", m_axis_tdata[95:48], w[95:48]);
                    if (m_axis_tdata[110:96] !== w[110:96])
                        report_mismatch("pose_heading", m_axis_tdata[110:96], w[110:96]);
                    if (m_axis_tdata[142:111] !== w[142:111])
                        report_mismatch("pose_time", m_axis_tdata[142:111], w[142:111]);
                end
                poses_seen++;
            end
        end
    end

    // tvalid stays up after an accept unless the next request idles first
    task automatic send_req(input t_req r);
        while (!calm && $urandom_range(99) < 18) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= r.mode;
        s_axis_tdata <= {r.tms, r.nh, r.ny, r.nx, r.head, r.odom};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        advance_pose(r);
        if (r.mode) sets_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_lateral(input logic [15:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        trk_lat = int'($signed(v));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(46080)) - 23040);
            default: return 16'($signed($urandom_range(2000)) - 1000);
        endcase
    endfunction

    function automatic t_req rand_req(input logic [31:0] odom, input logic [31:0] tms);
        t_req r;
        r.mode = ($urandom_range(99) < 8) ? MODE_SET : MODE_SAMPLE;
        r.odom = ($urandom_range(9) == 0) ? $urandom : odom;
        r.head = rand_angle();
        r.nx = $urandom;
        r.ny = $urandom;
        r.nh = rand_angle();
        r.tms = tms;
        if ($urandom_range(19) == 0) r.tms = $urandom;
        return r;
    endfunction

    t_row dir_rows[$];

    function automatic t_row mk(logic m, logic [31:0] o, logic [15:0] h, logic [31:0] x,
                                logic [31:0] y, logic [15:0] n, logic [31:0] t);
        t_row w;
        w.req = '{m, o, h, x, y, n, t};
        w.known = 0;
        w.px = '0; w.py = '0; w.ph = '0;
        return w;
    endfunction

    initial begin
        logic [15:0] lat_set[4] = '{16'h7FFF, 16'h8000, 16'd0, 16'd3000};
        logic [31:0] odom_acc, tms;
        t_row w;
        t_req r;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = 0;
        i_cfg_valid = 0;
        i_cfg_data = '0;
        trk_x = 0; trk_y = 0; trk_head = 0; trk_ofs = 0; trk_last_head = 0;
        trk_lat = 0; trk_last_odom = 0; trk_stamp = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // zero travel after reset leaves the pose at the origin
        w = mk(MODE_SAMPLE, 0, 0, 0, 0, 0, 5);
        w.known = 1;
        dir_rows.push_back(w);
        // set pose at the 32-bit extremes, heading wraps from -360
        w = mk(MODE_SET, 32'h7FFF_FFFF, 16'sh0, 32'h7FFF_FFFF, 32'h8000_0000,
               -16'sd23040, 9);
        w.known = 1;
        w.px = 48'h0000_7FFF_FFFF; w.py = 48'hFFFF_8000_0000; w.ph = 15'd0;
        dir_rows.push_back(w);
        // wheel difference wraps modulo 2^32
        dir_rows.push_back(mk(MODE_SAMPLE, 32'h8000_0000, 0, 0, 0, 0, 10));
        dir_rows.push_back(mk(MODE_SAMPLE, 32'h7FFF_FFFF, 16'd11520, 0, 0, 0, 11));
        dir_rows.push_back(mk(MODE_SAMPLE, 32'h0, -16'sd11520, 0, 0, 0, 12));
        dir_rows.push_back(mk(MODE_SAMPLE, 32'h7FFF_0000, 16'd5760, 0, 0, 0, 13));
        dir_rows.push_back(mk(MODE_SAMPLE, 32'h8000_0000, -16'sd5761, 0, 0, 0, 14));
        dir_rows.push_back(mk(MODE_SAMPLE, 32'h1000, 16'h7FFF, 0, 0, 0, 15));
        dir_rows.push_back(mk(MODE_SAMPLE, 32'h2000, 16'h8000, 0, 0, 0, 32'hFFFF_FFFF));
        dir_rows.push_back(mk(MODE_SET, 32'hFFFF_FFFF, 16'd23040, 32'h8000_0000,
                              32'h7FFF_FFFF, -16'sd23040, 0));
        dir_rows.push_back(mk(MODE_SAMPLE, 32'h7FFF_FFFE, 16'd100, 0, 0, 0, 1));
        dir_rows.push_back(mk(MODE_SET, 0, 16'd11520, 0, 0, -16'sd11520, 2));
        dir_rows.push_back(mk(MODE_SAMPLE, 32'd5000, 16'd11000, 0, 0, 0, 3));

        for (int ph = 0; ph < 4; ph++) begin
            write_lateral(lat_set[ph]);
            if (ph == 0) begin
                foreach (dir_rows[i]) begin
                    send_req(dir_rows[i].req);
                    if (dir_rows[i].known) begin
                        logic [143:0] p;
                        p = pose_q[$];
                        if (p[47:0] !== dir_rows[i].px || p[95:48] !== dir_rows[i].py ||
                            p[110:96] !== dir_rows[i].ph)
                            report_mismatch("table row", p[63:0], dir_rows[i].px);
                    end
                end
            end
            // start at the 32-bit corner, then a random run; in phase 1 its first 30 samples take maximal wheel steps
            r = '{MODE_SET, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0};
            send_req(r);
            odom_acc = 0;
            tms = 0;
            calm = (ph == 2);
            for (int k = 0; k < 175; k++) begin
                if (ph == 1 && k < 30) begin
                    odom_acc += 32'h7FFF_FFFF;
                    r = '{MODE_SAMPLE, odom_acc, 0, 0, 0, 0, tms};
                end else begin
                    odom_acc += $urandom_range(5000);
                    r = rand_req(odom_acc, tms);
                    if ($urandom_range(9) == 0) odom_acc = r.odom;
                end
                tms += 10;
                send_req(r);
            end
            calm = 0;
            wait_idle();
        end
        $display("Covered %0d poses with %0d set-pose requests over four lateral offsets,",
                 poses_seen, sets_sent);
        $display("including wrap, half-circle and large wheel step cases.");
        if (errors == 0 && pose_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/two_pkg.sv
rtl/core/two_ctrl.sv
rtl/core/two_dpath.sv
rtl/core/tracking_wheel_odometry.sv
dv/tracking_wheel_odometry_tb.sv
